/* rtl/vrrm_pkg.sv */
// Shared types, codes and helpers for the variable record ring manager.
package vrrm_pkg;

  localparam int unsigned MAX_CAPACITY_LOG2 = 16;
  localparam int unsigned MAX_RECORD_LEN    = 65527;

  localparam int unsigned HdrW  = 18;
  localparam int unsigned SizeW = 17;

  typedef enum logic [2:0] {
    ACT_RESERVE = 3'd0,
    ACT_SUBMIT  = 3'd1,
    ACT_DISCARD = 3'd2,
    ACT_NEXT    = 3'd3,
    ACT_RETURN  = 3'd4,
    ACT_QUERY   = 3'd5,
    ACT_RSVD6   = 3'd6,
    ACT_RSVD7   = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NOSPACE  = 2'd2,
    ST_NORECORD = 2'd3
  } status_e;

  localparam logic CFG_CAPACITY_LOG2 = 1'b0;
  localparam logic CFG_WAIT_ENABLED  = 1'b1;

  typedef struct packed {
    logic        discard;
    logic        lock;
    logic [15:0] len;
  } hdr_t;

  // header plus data, padded to a multiple of 8 bytes
  function automatic logic [SizeW-1:0] rec_size(input logic [15:0] len);
    logic [SizeW-1:0] sum;
    sum = {1'b0, len} + SizeW'(15);
    return {sum[SizeW-1:3], 3'b000};
  endfunction

endpackage

/* rtl/variable_record_ring_manager.sv */
// Top level: command sequencer for the variable record ring over a header RAM.
// Reserve, submit and discard add a RAM step after decode; query finishes in
// decode, as do commands that decode rejects. Next and return read one header
// (one RAM read) per walk step and end on a header or on an offset compare.
// One command at a time; busy drops in the done strobe cycle. Reset clears both
// offsets, restores register defaults; header RAM is undefined until written.
module variable_record_ring_manager #(
  parameter int unsigned MaxCapacityLog2 = vrrm_pkg::MAX_CAPACITY_LOG2,
  parameter int unsigned MaxRecordLen    = vrrm_pkg::MAX_RECORD_LEN
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic [15:0] request_length_i,
  input  logic [63:0] record_offset_i,
  input  logic [1:0]  wake_flags_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [63:0] result_offset_o,
  output logic [15:0] result_length_o,
  output logic [63:0] following_offset_o,
  output logic [63:0] consumer_position_o,
  output logic [63:0] producer_position_o,
  output logic        wake_consumer_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);
  import vrrm_pkg::*;

  localparam int unsigned SlotW = (MaxCapacityLog2 > 3) ? MaxCapacityLog2 - 3 : 1;
  localparam int unsigned Depth = 1 << (MaxCapacityLog2 - 3);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECODE    = 3'd1;
  localparam logic [2:0] S_RES_SPACE = 3'd2;
  localparam logic [2:0] S_MOD_WR    = 3'd3;
  localparam logic [2:0] S_WALK      = 3'd4;
  localparam logic [2:0] S_WALK_EVAL = 3'd5;
  localparam logic [2:0] S_RET_CHK   = 3'd6;
  localparam logic [2:0] S_RET_EVAL  = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [2:0]  act_q;
  logic [15:0] req_q;
  logic [63:0] roff_q;
  logic [1:0]  flags_q;
  logic [63:0] np_q, np_d;
  logic [63:0] walk_q, walk_d;
  logic [63:0] cons_q, cons_d;
  logic [63:0] prod_q, prod_d;
  logic        done_q, done_d;
  logic [1:0]  status_q, status_d;
  logic [63:0] roffo_q, roffo_d;
  logic [15:0] rlen_q, rlen_d;
  logic [63:0] rnext_q, rnext_d;
  logic        wake_q, wake_d;
  logic [4:0]  caplg_q;
  logic        wait_q;

  logic [4:0]       lg_eff;
  logic [63:0]      cap;
  logic [63:0]      addr_off;
  logic [SlotW-1:0] slot;
  logic             mem_we;
  hdr_t             mem_wdata;
  logic [HdrW-1:0]  mem_rdata;
  hdr_t             hdr;
  logic [SizeW-1:0] req_size;
  logic [SizeW-1:0] hdr_size;
  logic             wake_now;
  logic             accept;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  // take register writes only with no command in flight or arriving
  assign cfg_ready_o = !busy && !start;

  always_comb begin
    if (caplg_q < 5'd3) begin
      lg_eff = 5'd3;
    end else if (caplg_q > 5'(MaxCapacityLog2)) begin
      lg_eff = 5'(MaxCapacityLog2);
    end else begin
      lg_eff = caplg_q;
    end
  end

  assign cap = 64'd1 << lg_eff;

  always_comb begin
    unique case (state_q)
      S_WALK:      addr_off = cons_q;
      S_RET_CHK:   addr_off = walk_q;
      S_RES_SPACE: addr_off = prod_q;
      default:     addr_off = roff_q;
    endcase
  end

  // keep offset bits below the ring size only
  always_comb begin
    for (int k = 0; k < SlotW; k++) begin
      slot[k] = addr_off[k+3] && ((k + 3) < int'(lg_eff));
    end
  end

  assign hdr      = hdr_t'(mem_rdata);
  assign req_size = rec_size(req_q);
  assign hdr_size = rec_size(hdr.len);

  always_comb begin
    if (flags_q[1]) begin
      wake_now = wait_q;
    end else if (flags_q[0]) begin
      wake_now = 1'b0;
    end else begin
      wake_now = wait_q && (prod_q != cons_q);
    end
  end

  always_comb begin
    state_d   = state_q;
    np_d      = np_q;
    walk_d    = walk_q;
    cons_d    = cons_q;
    prod_d    = prod_q;
    done_d    = 1'b0;
    status_d  = status_q;
    roffo_d   = roffo_q;
    rlen_d    = rlen_q;
    rnext_d   = rnext_q;
    wake_d    = wake_q;
    mem_we    = 1'b0;
    mem_wdata = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        // most commands finish here; clear the result fields by default
        state_d  = S_IDLE;
        done_d   = 1'b1;
        status_d = ST_OK;
        roffo_d  = '0;
        rlen_d   = '0;
        rnext_d  = '0;
        wake_d   = 1'b0;
        unique case (action_e'(act_q))
          ACT_RESERVE: begin
            if ((64'(req_size) > cap) || (req_q == 16'd0) ||
                (32'(req_q) > 32'(MaxRecordLen))) begin
              status_d = ST_INVALID;
            end else begin
              np_d    = prod_q + 64'(req_size);
              done_d  = 1'b0;
              state_d = S_RES_SPACE;
            end
          end
          ACT_SUBMIT, ACT_DISCARD: begin
            if (roff_q[2:0] != 3'd0) begin
              status_d = ST_INVALID;
            end else begin
              done_d  = 1'b0;
              state_d = S_MOD_WR;
            end
          end
          ACT_NEXT: begin
            done_d  = 1'b0;
            state_d = S_WALK;
          end
          ACT_RETURN: begin
            if (roff_q > prod_q) begin
              status_d = ST_INVALID;
            end else begin
              walk_d  = cons_q;
              done_d  = 1'b0;
              state_d = S_RET_CHK;
            end
          end
          ACT_QUERY: begin
            status_d = ST_OK;
          end
          default: begin
            status_d = ST_INVALID;
          end
        endcase
      end
      S_RES_SPACE: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if ((np_q - cons_q) > cap) begin
          status_d = ST_NOSPACE;
        end else begin
          mem_we         = 1'b1;
          mem_wdata.len  = req_q;
          mem_wdata.lock = 1'b1;
          roffo_d        = prod_q;
          prod_d         = np_q;
        end
      end
      S_MOD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = hdr;
        mem_wdata.lock = 1'b0;
        if (action_e'(act_q) == ACT_SUBMIT) begin
          mem_wdata.discard = 1'b0;
        end else begin
          mem_wdata.discard = 1'b1;
        end
        wake_d  = wake_now;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_WALK: begin
        if (prod_q > cons_q) begin
          state_d = S_WALK_EVAL;
        end else begin
          status_d = ST_NORECORD;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_WALK_EVAL: begin
        if (hdr.lock) begin
          status_d = ST_NORECORD;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (!hdr.discard) begin
          roffo_d = cons_q;
          rlen_d  = hdr.len;
          rnext_d = cons_q + 64'(hdr_size);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          // free the discarded record and keep walking
          cons_d  = cons_q + 64'(hdr_size);
          state_d = S_WALK;
        end
      end
      S_RET_CHK: begin
        if (walk_q < roff_q) begin
          state_d = S_RET_EVAL;
        end else begin
          if (walk_q == roff_q) begin
            cons_d = roff_q;
          end else begin
            status_d = ST_INVALID;
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RET_EVAL: begin
        if (hdr.lock) begin
          status_d = ST_INVALID;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          walk_d  = walk_q + 64'(hdr_size);
          state_d = S_RET_CHK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cons_q  <= '0;
      prod_q  <= '0;
      done_q  <= 1'b0;
      caplg_q <= 5'd16;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cons_q  <= cons_d;
      prod_q  <= prod_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_CAPACITY_LOG2) begin
          caplg_q <= cfg_data_i;
        end else begin
          wait_q <= cfg_data_i[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_i;
      req_q   <= request_length_i;
      roff_q  <= record_offset_i;
      flags_q <= wake_flags_i;
    end
    np_q     <= np_d;
    walk_q   <= walk_d;
    status_q <= status_d;
    roffo_q  <= roffo_d;
    rlen_q   <= rlen_d;
    rnext_q  <= rnext_d;
    wake_q   <= wake_d;
  end

  vrrm_ram #(
    .Width(HdrW),
    .Depth(Depth),
    .AddrW(SlotW)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(slot),
    .wdata_i(mem_wdata),
    .raddr_i(slot),
    .rdata_o(mem_rdata)
  );

  assign done_o              = done_q;
  assign status_o            = status_q;
  assign result_offset_o     = roffo_q;
  assign result_length_o     = rlen_q;
  assign following_offset_o  = rnext_q;
  assign consumer_position_o = cons_q;
  assign producer_position_o = prod_q;
  assign wake_consumer_o     = wake_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("done strobe while busy");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");

  a_write_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> done_o)
    else $error("header write not followed by completion");

endmodule

/* rtl/vrrm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module vrrm_ram #(
  parameter int unsigned Width = 18,
  parameter int unsigned Depth = 8192,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* bench/tb_variable_record_ring_manager.sv */
// Self-checking testbench for the variable record ring manager.
`timescale 1ns / 100ps

module tb_variable_record_ring_manager;
  import vrrm_pkg::*;

  typedef struct {
    status_e     st;
    logic [63:0] rec_off;
    logic [15:0] rec_len;
    logic [63:0] rec_next;
    logic [63:0] cons;
    logic [63:0] prod;
    logic        wake;
  } ring_result_t;

  localparam int unsigned SLOTS = 1 << (MAX_CAPACITY_LOG2 - 3);
  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  action_i = '0;
  logic [15:0] request_length_i = '0;
  logic [63:0] record_offset_i = '0;
  logic [1:0]  wake_flags_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [63:0] result_offset_o, following_offset_o, consumer_position_o, producer_position_o;
  logic [15:0] result_length_o;
  logic        wake_consumer_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [4:0]  cfg_data_i = '0;

  variable_record_ring_manager dut (.*);

  // shadow state of the ring
  logic [4:0]  cap_lg;
  logic        wait_en;
  logic [63:0] cons_pos, prod_pos;
  logic [17:0] hdr_mem [SLOTS];
  bit          hdr_written [SLOTS];
  logic [63:0] locked_q [$];
  logic [63:0] found_next;

  ring_result_t expected_q [$];
  int          errors = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] ring_cap();
    logic [4:0] lg;
    lg = cap_lg;
    if (lg < 5'd3) lg = 5'd3;
    if (lg > 5'(MAX_CAPACITY_LOG2)) lg = 5'(MAX_CAPACITY_LOG2);
    return 64'd1 << lg;
  endfunction

  function automatic int unsigned slot_of(logic [63:0] off);
    logic [63:0] s;
    s = (off & (ring_cap() - 64'd1)) >> 3;
    return 32'(s[12:0]);
  endfunction

  function automatic logic [63:0] padded_size(logic [15:0] len);
    return ({48'd0, len} + 64'd15) & ~64'd7;
  endfunction

  function automatic bit wake_for(logic [1:0] flags);
    if (flags[1]) return wait_en;
    if (flags[0]) return 1'b0;
    return wait_en && (prod_pos != cons_pos);
  endfunction

  // True when the command touches only header entries already written.
  function automatic bit touches_written(action_e act, logic [63:0] off);
    logic [63:0] w;
    logic [17:0] h;
    int unsigned i;
    case (act)
      ACT_SUBMIT, ACT_DISCARD: return (off[2:0] != 0) || hdr_written[slot_of(off)];
      ACT_NEXT: begin
        w = cons_pos;
        while (prod_pos > w) begin
          i = slot_of(w);
          if (!hdr_written[i]) return 1'b0;
          h = hdr_mem[i];
          if (h[16] || !h[17]) return 1'b1;
          w += padded_size(h[15:0]);
        end
        return 1'b1;
      end
      ACT_RETURN: begin
        if (off > prod_pos) return 1'b1;
        w = cons_pos;
        while (w < off) begin
          i = slot_of(w);
          if (!hdr_written[i]) return 1'b0;
          h = hdr_mem[i];
          if (h[16]) return 1'b1;
          w += padded_size(h[15:0]);
        end
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic ring_result_t ring_predict(action_e act, logic [15:0] len,
                                                logic [63:0] off, logic [1:0] flags);
    ring_result_t r;
    logic [63:0] cap, sz, np, w;
    logic [17:0] h;
    int unsigned i;
    r = '{ST_OK, 64'd0, 16'd0, 64'd0, 64'd0, 64'd0, 1'b0};
    cap = ring_cap();
    case (act)
      ACT_RESERVE: begin
        sz = padded_size(len);
        if (sz > cap || len == 0 || len > MAX_RECORD_LEN) r.st = ST_INVALID;
        else begin
          np = prod_pos + sz;
          if (np - cons_pos > cap) r.st = ST_NOSPACE;
          else begin
            i = slot_of(prod_pos);
            hdr_mem[i] = {2'b01, len};
            hdr_written[i] = 1'b1;
            r.rec_off = prod_pos;
            prod_pos = np;
          end
        end
      end
      ACT_SUBMIT, ACT_DISCARD: begin
        if (off[2:0] != 0) r.st = ST_INVALID;
        else begin
          i = slot_of(off);
          h = hdr_mem[i];
          if (act == ACT_SUBMIT) h = {2'b00, h[15:0]};
          else h = {1'b1, 1'b0, h[15:0]};
          hdr_mem[i] = h;
          r.wake = wake_for(flags);
        end
      end
      ACT_NEXT: begin
        r.st = ST_NORECORD;
        while (prod_pos > cons_pos) begin
          h = hdr_mem[slot_of(cons_pos)];
          if (h[16]) break;
          sz = padded_size(h[15:0]);
          if (!h[17]) begin
            r.st = ST_OK;
            r.rec_off = cons_pos;
            r.rec_len = h[15:0];
            r.rec_next = cons_pos + sz;
            break;
          end
          cons_pos += sz;
        end
      end
      ACT_RETURN: begin
        if (off > prod_pos) r.st = ST_INVALID;
        else begin
          w = cons_pos;
          while (w < off) begin
            h = hdr_mem[slot_of(w)];
            if (h[16]) begin
              r.st = ST_INVALID;
              break;
            end
            w += padded_size(h[15:0]);
          end
          if (r.st == ST_OK && w != off) r.st = ST_INVALID;
          if (r.st == ST_OK) cons_pos = off;
        end
      end
      ACT_QUERY: r.st = ST_OK;
      default: r.st = ST_INVALID;
    endcase
    r.cons = cons_pos;
    r.prod = prod_pos;
    return r;
  endfunction

  // Compare every completed transaction against the oldest expectation.
  always @(posedge clk_i) begin
    ring_result_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (status_o != e.st) begin
          $error("status exp %0d got %0d", e.st, status_o); errors++;
        end
        if (result_offset_o != e.rec_off) begin
          $error("result_offset exp %0h got %0h", e.rec_off, result_offset_o); errors++;
        end
        if (result_length_o != e.rec_len) begin
          $error("result_length exp %0d got %0d", e.rec_len, result_length_o); errors++;
        end
        if (following_offset_o != e.rec_next) begin
          $error("following_offset exp %0h got %0h", e.rec_next, following_offset_o);
          errors++;
        end
        if (consumer_position_o != e.cons) begin
          $error("consumer_position exp %0h got %0h", e.cons, consumer_position_o); errors++;
        end
        if (producer_position_o != e.prod) begin
          $error("producer_position exp %0h got %0h", e.prod, producer_position_o); errors++;
        end
        if (wake_consumer_o != e.wake) begin
          $error("wake_consumer exp %0b got %0b", e.wake, wake_consumer_o); errors++;
        end
      end
    end
  end

  task automatic send_cmd(action_e act, logic [15:0] len, logic [63:0] off,
                          logic [1:0] flags);
    ring_result_t r;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    action_i = act;
    request_length_i = len;
    record_offset_i = off;
    wake_flags_i = flags;
    start = 1'b1;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    r = ring_predict(act, len, off, flags);
    if (act == ACT_NEXT && r.st == ST_OK) found_next = r.rec_next;
    if (act == ACT_RESERVE && r.st == ST_OK) locked_q.push_back(r.rec_off);
    expected_q.push_back(r);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [4:0] val);
    drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_CAPACITY_LOG2) cap_lg = val;
    else wait_en = val[0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_directed();
    send_cmd(ACT_RESERVE, 16'd0, 64'd0, 2'b00);
    send_cmd(ACT_RESERVE, 16'd65528, 64'd0, 2'b00);
    send_cmd(ACT_RESERVE, 16'hFFFF, 64'd0, 2'b00);
    send_cmd(ACT_RESERVE, 16'd65527, 64'd0, 2'b00);   // fills the whole ring
    send_cmd(ACT_RESERVE, 16'd1, 64'd0, 2'b00);       // no space
    send_cmd(ACT_NEXT, 16'd0, 64'd0, 2'b00);          // locked head
    send_cmd(ACT_RETURN, 16'd0, 64'd8, 2'b00);        // locked during walk
    send_cmd(ACT_SUBMIT, 16'd0, 64'd0, 2'b00);
    send_cmd(ACT_NEXT, 16'd0, 64'd0, 2'b00);
    send_cmd(ACT_RETURN, 16'd0, 64'd8, 2'b00);        // overshoot
    send_cmd(ACT_RETURN, 16'd0, 64'hFFFF_FFFF_FFFF_FFF8, 2'b00);
    send_cmd(ACT_RETURN, 16'd0, 64'd65536, 2'b00);
    send_cmd(ACT_NEXT, 16'd0, 64'd0, 2'b00);          // ring empty
    send_cmd(ACT_QUERY, 16'd0, 64'd0, 2'b00);
    send_cmd(ACT_RSVD6, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 2'b11);
    send_cmd(ACT_RSVD7, 16'd0, 64'd0, 2'b00);
    send_cmd(ACT_RESERVE, 16'd5, 64'd0, 2'b00);
    send_cmd(ACT_DISCARD, 16'd0, 64'd65536, 2'b10);
    send_cmd(ACT_RESERVE, 16'd10, 64'd0, 2'b00);
    send_cmd(ACT_SUBMIT, 16'd0, 64'd65552, 2'b01);
    send_cmd(ACT_SUBMIT, 16'd0, 64'hFFFF_FFFF_FFFF_FFFB, 2'b00);
    send_cmd(ACT_DISCARD, 16'd0, 64'h0000_0000_0000_0003, 2'b11);
    send_cmd(ACT_NEXT, 16'd0, 64'd0, 2'b00);          // skip discarded record
    send_cmd(ACT_RETURN, 16'd0, found_next, 2'b00);
  endtask

  task automatic test_random(int n);
    action_e     act;
    logic [15:0] len;
    logic [63:0] off;
    int unsigned pick, k;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      len = 16'($urandom);
      off = {$urandom, $urandom};
      if (pick < 32) begin
        act = ACT_RESERVE;
        if ($urandom_range(0, 9) != 0) len = 16'($urandom_range(1, 120));
      end else if (pick < 62) begin
        act = ($urandom_range(0, 1) != 0) ? ACT_SUBMIT : ACT_DISCARD;
        if (locked_q.size() != 0 && $urandom_range(0, 9) != 0) begin
          k = $urandom_range(0, locked_q.size() - 1);
          off = locked_q[k];
          locked_q.delete(k);
        end else if (off[2:0] == 0) off[0] = 1'b1;
      end else if (pick < 80) begin
        act = ACT_NEXT;
      end else if (pick < 92) begin
        act = ACT_RETURN;
        case ($urandom_range(0, 4))
          0, 1: off = found_next;
          2: off = cons_pos;
          3: off = prod_pos;
          default: off[63] = 1'b1;
        endcase
      end else if (pick < 96) begin
        act = ACT_QUERY;
      end else begin
        act = ($urandom_range(0, 1) != 0) ? ACT_RSVD6 : ACT_RSVD7;
      end
      if (!touches_written(act, off)) act = ACT_QUERY;
      send_cmd(act, len, off, 2'($urandom));
    end
  endtask

  task automatic test_capacity_sweep();
    write_reg(CFG_CAPACITY_LOG2, 5'd4);
    write_reg(CFG_WAIT_ENABLED, 5'd1);
    test_random(60);
    write_reg(CFG_CAPACITY_LOG2, 5'd3);
    test_random(20);
    write_reg(CFG_CAPACITY_LOG2, 5'd0);
    test_random(20);
    write_reg(CFG_CAPACITY_LOG2, 5'd31);
    write_reg(CFG_WAIT_ENABLED, 5'd0);
    test_random(60);
    write_reg(CFG_CAPACITY_LOG2, 5'd9);
    write_reg(CFG_WAIT_ENABLED, 5'd1);
    test_random(60);
  endtask

  task automatic test_hold_off();
    drain();
    test_random(40);
  endtask

  initial begin
    cap_lg = 5'd16;
    wait_en = 1'b0;
    cons_pos = '0;
    prod_pos = '0;
    found_next = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hdr_mem[i] = '0;
      hdr_written[i] = 1'b0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    write_reg(CFG_WAIT_ENABLED, 5'd1);
    test_random(60);
    test_capacity_sweep();
    test_hold_off();
    write_reg(CFG_CAPACITY_LOG2, 5'd16);
    idle_on = 1'b0;
    test_random(80);

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
